// ===== sv/cpu8_abe_pkg.sv =====
// Package: types, opcode classes, reset values and helpers for the 6502 execute unit
package cpu8_abe_pkg;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [7:0]  operand;
        logic [15:0] next_pc;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pc_out;
        logic        mem_write;
        logic [7:0]  write_data;
        logic [7:0]  acc_value;
        logic [7:0]  x_value;
        logic [7:0]  y_value;
        logic [7:0]  sp_value;
        logic [7:0]  flags_value;
        logic [1:0]  cycle_code;
        logic        unsupported;
    } t_out_item;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] s;
        logic [7:0] p;
    } t_arch;

    typedef enum logic [5:0] {
        CL_U, CL_ORA, CL_AND, CL_EOR, CL_ADD, CL_SUB, CL_CMP, CL_CPX, CL_CPY, CL_BIT,
        CL_LDA, CL_LDX, CL_LDY, CL_STA, CL_STX, CL_STY, CL_ASL, CL_ROL, CL_LSR, CL_ROR,
        CL_INC, CL_DEC, CL_INX, CL_INY, CL_DEX, CL_DEY, CL_TAX, CL_TAY, CL_TXA, CL_TYA,
        CL_TSX, CL_TXS, CL_CLC, CL_SEC, CL_CLI, CL_SEI, CL_CLV, CL_CLD, CL_SED, CL_NOP,
        CL_BRK, CL_BR, CL_STK
    } t_op_class;

    localparam logic [7:0]  RST_A      = 8'h00;
    localparam logic [7:0]  RST_X      = 8'h00;
    localparam logic [7:0]  RST_Y      = 8'h00;
    localparam logic [7:0]  RST_S      = 8'hFD;
    localparam logic [7:0]  RST_P      = 8'h24;
    localparam logic [15:0] BRK_VECTOR = 16'hFFFE;

    localparam logic [1:0] CYC_NONE  = 2'd0;
    localparam logic [1:0] CYC_ONE   = 2'd1;
    localparam logic [1:0] CYC_TWO   = 2'd2;
    localparam logic [1:0] CYC_THREE = 2'd3;

    // status bit positions
    localparam int P_C = 0;
    localparam int P_Z = 1;
    localparam int P_I = 2;
    localparam int P_D = 3;
    localparam int P_V = 6;
    localparam int P_N = 7;

    function automatic logic [7:0] f_set_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] q;
        q      = p;
        q[P_N] = v[7];
        q[P_Z] = (v == 8'h00);
        return q;
    endfunction

endpackage

// ===== sv/cpu8_abe_in_if.sv =====
// Interface: instruction input channel
interface cpu8_abe_in_if;
    logic                   valid;
    logic                   ready;
    cpu8_abe_pkg::t_in_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== sv/cpu8_abe_out_if.sv =====
// Interface: execute result output channel
interface cpu8_abe_out_if;
    logic                    valid;
    logic                    ready;
    cpu8_abe_pkg::t_out_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== sv/cpu8_abe_dec.sv =====
// Opcode decoder: maps a 6502 opcode byte to its operation class
module cpu8_abe_dec (
    input  logic [7:0]              i_opcode,
    output cpu8_abe_pkg::t_op_class o_class
);
    import cpu8_abe_pkg::*;

    always_comb begin
        case (i_opcode)
            8'h01, 8'h05, 8'h09, 8'h0D, 8'h11, 8'h15, 8'h19, 8'h1D: o_class = CL_ORA;
            8'h21, 8'h25, 8'h29, 8'h2D, 8'h31, 8'h35, 8'h39, 8'h3D: o_class = CL_AND;
            8'h41, 8'h45, 8'h49, 8'h4D, 8'h51, 8'h55, 8'h59, 8'h5D: o_class = CL_EOR;
            8'h61, 8'h65, 8'h69, 8'h6D, 8'h71, 8'h75, 8'h79, 8'h7D: o_class = CL_ADD;
            8'hE1, 8'hE5, 8'hE9, 8'hED, 8'hF1, 8'hF5, 8'hF9, 8'hFD,
            8'hEB:                                                  o_class = CL_SUB;
            8'hC1, 8'hC5, 8'hC9, 8'hCD, 8'hD1, 8'hD5, 8'hD9, 8'hDD: o_class = CL_CMP;
            8'hA1, 8'hA5, 8'hA9, 8'hAD, 8'hB1, 8'hB5, 8'hB9, 8'hBD: o_class = CL_LDA;
            8'h81, 8'h85, 8'h8D, 8'h91, 8'h95, 8'h99, 8'h9D:        o_class = CL_STA;
            8'hE0, 8'hE4, 8'hEC:                                    o_class = CL_CPX;
            8'hC0, 8'hC4, 8'hCC:                                    o_class = CL_CPY;
            8'h24, 8'h2C:                                           o_class = CL_BIT;
            8'hA2, 8'hA6, 8'hAE, 8'hB6, 8'hBE:                      o_class = CL_LDX;
            8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC:                      o_class = CL_LDY;
            8'h86, 8'h8E, 8'h96:                                    o_class = CL_STX;
            8'h84, 8'h8C, 8'h94:                                    o_class = CL_STY;
            8'h06, 8'h0A, 8'h0E, 8'h16, 8'h1E:                      o_class = CL_ASL;
            8'h26, 8'h2A, 8'h2E, 8'h36, 8'h3E:                      o_class = CL_ROL;
            8'h46, 8'h4A, 8'h4E, 8'h56, 8'h5E:                      o_class = CL_LSR;
            8'h66, 8'h6A, 8'h6E, 8'h76, 8'h7E:                      o_class = CL_ROR;
            8'hE6, 8'hEE, 8'hF6, 8'hFE:                             o_class = CL_INC;
            8'hC6, 8'hCE, 8'hD6, 8'hDE:                             o_class = CL_DEC;
            8'hE8:                                                  o_class = CL_INX;
            8'hC8:                                                  o_class = CL_INY;
            8'hCA:                                                  o_class = CL_DEX;
            8'h88:                                                  o_class = CL_DEY;
            8'hAA:                                                  o_class = CL_TAX;
            8'hA8:                                                  o_class = CL_TAY;
            8'h8A:                                                  o_class = CL_TXA;
            8'h98:                                                  o_class = CL_TYA;
            8'hBA:                                                  o_class = CL_TSX;
            8'h9A:                                                  o_class = CL_TXS;
            8'h18:                                                  o_class = CL_CLC;
            8'h38:                                                  o_class = CL_SEC;
            8'h58:                                                  o_class = CL_CLI;
            8'h78:                                                  o_class = CL_SEI;
            8'hB8:                                                  o_class = CL_CLV;
            8'hD8:                                                  o_class = CL_CLD;
            8'hF8:                                                  o_class = CL_SED;
            8'h00:                                                  o_class = CL_BRK;
            8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0: o_class = CL_BR;
            8'h08, 8'h20, 8'h28, 8'h40, 8'h48, 8'h4C, 8'h60, 8'h68,
            8'h6C:                                                  o_class = CL_STK;
            8'h04, 8'h0C, 8'h14, 8'h1A, 8'h1C, 8'h34, 8'h3A, 8'h3C,
            8'h44, 8'h54, 8'h5A, 8'h5C, 8'h64, 8'h74, 8'h7A, 8'h7C,
            8'h80, 8'h82, 8'h89, 8'hC2, 8'hD4, 8'hDA, 8'hDC, 8'hE2,
            8'hEA, 8'hF4, 8'hFA, 8'hFC:                             o_class = CL_NOP;
            default:                                                o_class = CL_U;
        endcase
    end

endmodule

// ===== sv/cpu8_abe_exec.sv =====
// Execute logic: ALU, flags, branch target and next register state for one instruction
module cpu8_abe_exec (
    input  cpu8_abe_pkg::t_op_class i_class,
    input  cpu8_abe_pkg::t_in_item  i_item,
    input  cpu8_abe_pkg::t_arch     i_arch,
    output cpu8_abe_pkg::t_arch     o_arch,
    output cpu8_abe_pkg::t_out_item o_res
);
    import cpu8_abe_pkg::*;

    logic [7:0]  op;
    logic [7:0]  m;
    logic [15:0] pc;
    logic        acc_mode;
    logic [7:0]  shv;
    logic [7:0]  addend;
    logic [8:0]  sum;
    logic [7:0]  cmp_reg;
    logic [8:0]  diff;
    logic        br_flag;
    logic [15:0] br_tgt;

    assign op       = i_item.opcode;
    assign m        = i_item.operand;
    assign pc       = i_item.next_pc;
    assign acc_mode = (op[3:0] == 4'hA);
    assign shv      = acc_mode ? i_arch.a : m;
    assign addend   = (i_class == CL_SUB) ? ~m : m;
    assign sum      = {1'b0, i_arch.a} + {1'b0, addend} + {8'h00, i_arch.p[P_C]};
    assign cmp_reg  = (i_class == CL_CPX) ? i_arch.x :
                      (i_class == CL_CPY) ? i_arch.y : i_arch.a;
    assign diff     = {1'b0, cmp_reg} - {1'b0, m};
    assign br_tgt   = pc + {{8{m[7]}}, m};

    always_comb begin
        case (op[7:6])
            2'd0:    br_flag = i_arch.p[P_N];
            2'd1:    br_flag = i_arch.p[P_V];
            2'd2:    br_flag = i_arch.p[P_C];
            default: br_flag = i_arch.p[P_Z];
        endcase
    end

    always_comb begin
        logic [7:0] r;
        r                 = 8'h00;
        o_arch            = i_arch;
        o_res.pc_out      = pc;
        o_res.mem_write   = 1'b0;
        o_res.write_data  = 8'h00;
        o_res.cycle_code  = CYC_ONE;
        o_res.unsupported = 1'b0;

        case (i_class)
            CL_ORA: begin
                o_arch.a = i_arch.a | m;
                o_arch.p = f_set_nz(i_arch.p, o_arch.a);
            end
            CL_AND: begin
                o_arch.a = i_arch.a & m;
                o_arch.p = f_set_nz(i_arch.p, o_arch.a);
            end
            CL_EOR: begin
                o_arch.a = i_arch.a ^ m;
                o_arch.p = f_set_nz(i_arch.p, o_arch.a);
            end
            CL_ADD, CL_SUB: begin
                o_arch.a      = sum[7:0];
                o_arch.p      = f_set_nz(i_arch.p, sum[7:0]);
                o_arch.p[P_C] = sum[8];
                o_arch.p[P_V] = (i_arch.a[7] ^ sum[7]) & (addend[7] ^ sum[7]);
            end
            CL_CMP, CL_CPX, CL_CPY: begin
                o_arch.p      = f_set_nz(i_arch.p, diff[7:0]);
                o_arch.p[P_C] = ~diff[8];
            end
            CL_BIT: begin
                o_arch.p[P_N] = m[7];
                o_arch.p[P_V] = m[6];
                o_arch.p[P_Z] = ((i_arch.a & m) == 8'h00);
            end
            CL_LDA: begin
                o_arch.a = m;
                o_arch.p = f_set_nz(i_arch.p, m);
            end
            CL_LDX: begin
                o_arch.x = m;
                o_arch.p = f_set_nz(i_arch.p, m);
            end
            CL_LDY: begin
                o_arch.y = m;
                o_arch.p = f_set_nz(i_arch.p, m);
            end
            CL_STA: begin
                o_res.mem_write  = 1'b1;
                o_res.write_data = i_arch.a;
            end
            CL_STX: begin
                o_res.mem_write  = 1'b1;
                o_res.write_data = i_arch.x;
            end
            CL_STY: begin
                o_res.mem_write  = 1'b1;
                o_res.write_data = i_arch.y;
            end
            CL_ASL, CL_ROL, CL_LSR, CL_ROR: begin
                o_res.cycle_code = CYC_TWO;
                if (i_class == CL_ASL) begin
                    r = {shv[6:0], 1'b0};
                end else if (i_class == CL_ROL) begin
                    r = {shv[6:0], i_arch.p[P_C]};
                end else if (i_class == CL_LSR) begin
                    r = {1'b0, shv[7:1]};
                end else begin
                    r = {i_arch.p[P_C], shv[7:1]};
                end
                o_arch.p = f_set_nz(i_arch.p, r);
                if ((i_class == CL_ASL) || (i_class == CL_ROL)) begin
                    o_arch.p[P_C] = shv[7];
                end else begin
                    o_arch.p[P_C] = shv[0];
                end
                if (acc_mode) begin
                    o_arch.a = r;
                end else begin
                    o_res.mem_write  = 1'b1;
                    o_res.write_data = r;
                end
            end
            CL_INC, CL_DEC: begin
                o_res.cycle_code = CYC_TWO;
                r                = (i_class == CL_INC) ? m + 8'd1 : m - 8'd1;
                o_arch.p         = f_set_nz(i_arch.p, r);
                o_res.mem_write  = 1'b1;
                o_res.write_data = r;
            end
            CL_INX, CL_DEX: begin
                o_res.cycle_code = CYC_TWO;
                o_arch.x = (i_class == CL_INX) ? i_arch.x + 8'd1 : i_arch.x - 8'd1;
                o_arch.p = f_set_nz(i_arch.p, o_arch.x);
            end
            CL_INY, CL_DEY: begin
                o_res.cycle_code = CYC_TWO;
                o_arch.y = (i_class == CL_INY) ? i_arch.y + 8'd1 : i_arch.y - 8'd1;
                o_arch.p = f_set_nz(i_arch.p, o_arch.y);
            end
            CL_TAX: begin
                o_res.cycle_code = CYC_TWO;
                o_arch.x         = i_arch.a;
                o_arch.p         = f_set_nz(i_arch.p, i_arch.a);
            end
            CL_TAY: begin
                o_res.cycle_code = CYC_TWO;
                o_arch.y         = i_arch.a;
                o_arch.p         = f_set_nz(i_arch.p, i_arch.a);
            end
            CL_TXA: begin
                o_res.cycle_code = CYC_TWO;
                o_arch.a         = i_arch.x;
                o_arch.p         = f_set_nz(i_arch.p, i_arch.x);
            end
            CL_TYA: begin
                o_res.cycle_code = CYC_TWO;
                o_arch.a         = i_arch.y;
                o_arch.p         = f_set_nz(i_arch.p, i_arch.y);
            end
            CL_TSX: begin
                o_res.cycle_code = CYC_TWO;
                o_arch.x         = i_arch.s;
                o_arch.p         = f_set_nz(i_arch.p, i_arch.s);
            end
            CL_TXS: begin
                o_res.cycle_code = CYC_TWO;
                o_arch.s         = i_arch.x;
            end
            CL_CLC: begin
                o_res.cycle_code = CYC_TWO;
                o_arch.p[P_C]    = 1'b0;
            end
            CL_SEC: begin
                o_res.cycle_code = CYC_TWO;
                o_arch.p[P_C]    = 1'b1;
            end
            CL_CLI: begin
                o_res.cycle_code = CYC_TWO;
                o_arch.p[P_I]    = 1'b0;
            end
            CL_SEI: begin
                o_res.cycle_code = CYC_TWO;
                o_arch.p[P_I]    = 1'b1;
            end
            CL_CLV: begin
                o_res.cycle_code = CYC_TWO;
                o_arch.p[P_V]    = 1'b0;
            end
            CL_CLD: begin
                o_res.cycle_code = CYC_TWO;
                o_arch.p[P_D]    = 1'b0;
            end
            CL_SED: begin
                o_res.cycle_code = CYC_TWO;
                o_arch.p[P_D]    = 1'b1;
            end
            CL_NOP: begin
                o_res.cycle_code = CYC_TWO;
            end
            CL_BRK: begin
                o_res.cycle_code = CYC_THREE;
                o_arch.p[P_I]    = 1'b1;
                o_res.pc_out     = BRK_VECTOR;
            end
            CL_BR: begin
                if (br_flag == op[5]) begin
                    o_res.pc_out     = br_tgt;
                    o_res.cycle_code = (br_tgt[15:8] != pc[15:8]) ? CYC_TWO : CYC_ONE;
                end
            end
            CL_STK: begin
                o_res.unsupported = 1'b1;
            end
            default: begin
                o_res.unsupported = 1'b1;
                o_res.cycle_code  = CYC_NONE;
            end
        endcase

        o_res.acc_value   = o_arch.a;
        o_res.x_value     = o_arch.x;
        o_res.y_value     = o_arch.y;
        o_res.sp_value    = o_arch.s;
        o_res.flags_value = o_arch.p;
    end

endmodule

// ===== sv/cpu8_alu_branch_execute_top.sv =====
// Top level: 6502 execute unit (binary arithmetic only) with input and result registers
//
//  Channel | Modport | Payload                                   | Transfer
//  i_in    | sink    | opcode, operand, next_pc                  | valid && ready
//  o_out   | source  | pc_out, mem_write, write_data, registers, | valid && ready
//          |         | flags_value, cycle_code, unsupported      |
//
// One instruction per clock sustained while o_out is not stalled; the result is registered behind the input register.
// The instruction executes as it moves from the input register to the result register,
// and A, X, Y, S, P update on that same edge, so the next instruction sees them at once.
// Reset: A=X=Y=0, S=0xFD, P=0x24, both registers empty.
// A stalled result holds the result register; the input register still takes one more item.
module cpu8_alu_branch_execute_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cpu8_abe_in_if.sink           i_in,
    cpu8_abe_out_if.source        o_out
);
    import cpu8_abe_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_arch     r_arch;

    t_op_class cls;
    t_arch     n_arch;
    t_out_item n_out;
    logic      out_free;
    logic      advance;
    logic      in_xfer;

    assign out_free    = !r_out_valid || o_out.ready;
    assign advance     = r_in_valid && out_free;
    assign i_in.ready  = !r_in_valid || out_free;
    assign in_xfer     = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    cpu8_abe_dec u_dec (
        .i_opcode (r_in.opcode),
        .o_class  (cls)
    );

    cpu8_abe_exec u_exec (
        .i_class (cls),
        .i_item  (r_in),
        .i_arch  (r_arch),
        .o_arch  (n_arch),
        .o_res   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_arch      <= '{a: RST_A, x: RST_X, y: RST_Y, s: RST_S, p: RST_P};
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_arch <= n_arch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in.data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTH
    a_arch_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_arch))
        else $error("register file changed without an executed instruction");

    a_unsup_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.unsupported) |-> !o_out.data.mem_write)
        else $error("unsupported opcode produced a memory write");

    a_wdata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.mem_write) |-> (o_out.data.write_data == 8'h00))
        else $error("write data nonzero without a memory write");

    a_flag_bit5: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.data.flags_value[5])
        else $error("status bit 5 cleared");
`endif

endmodule

// ===== tb/tb_cpu8_alu_branch_execute_top.sv =====
// Testbench: self-checking random and directed test of the 6502 execute unit
module tb_cpu8_alu_branch_execute_top;
    import cpu8_abe_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int HOLD_CYCLES    = 300;

    localparam logic [7:0] OP_BRK     = 8'h00;
    localparam logic [7:0] OP_CLC     = 8'h18;
    localparam logic [7:0] OP_SEC     = 8'h38;
    localparam logic [7:0] OP_CLV     = 8'hB8;
    localparam logic [7:0] OP_SED     = 8'hF8;
    localparam logic [7:0] OP_LDA_IMM = 8'hA9;
    localparam logic [7:0] OP_ADC_IMM = 8'h69;
    localparam logic [7:0] OP_SBC_IMM = 8'hE9;
    localparam logic [7:0] OP_SBC_ALT = 8'hEB;
    localparam logic [7:0] OP_CMP_IMM = 8'hC9;
    localparam logic [7:0] OP_CPX_IMM = 8'hE0;
    localparam logic [7:0] OP_BIT_ZP  = 8'h24;
    localparam logic [7:0] OP_ASL_A   = 8'h0A;
    localparam logic [7:0] OP_ROL_A   = 8'h2A;
    localparam logic [7:0] OP_LSR_ZP  = 8'h46;
    localparam logic [7:0] OP_ROR_ZP  = 8'h66;
    localparam logic [7:0] OP_INC_ZP  = 8'hE6;
    localparam logic [7:0] OP_DEC_ZP  = 8'hC6;
    localparam logic [7:0] OP_STA_ZP  = 8'h85;
    localparam logic [7:0] OP_TXS     = 8'h9A;
    localparam logic [7:0] OP_TSX     = 8'hBA;
    localparam logic [7:0] OP_BCS     = 8'hB0;
    localparam logic [7:0] OP_BNE     = 8'hD0;
    localparam logic [7:0] OP_BEQ     = 8'hF0;
    localparam logic [7:0] OP_PHA     = 8'h48;
    localparam logic [7:0] OP_NOP_IMM = 8'h89;
    localparam logic [7:0] OP_JAM     = 8'h02;
    localparam logic [4:0] BRANCH_LOW = 5'b10000;

    logic clk = 1'b0;
    logic rst_n;

    cpu8_abe_in_if  in_ch();
    cpu8_abe_out_if out_ch();

    cpu8_alu_branch_execute_top u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #1 clk = ~clk;

    t_arch     cpu_regs;
    t_out_item expected_results[$];
    t_out_item want;

    int  mismatch_count = 0;
    int  instr_count    = 0;
    int  result_count   = 0;
    int  write_count    = 0;
    int  unsup_count    = 0;
    int  quiet_cycles   = 0;
    int  hold_request   = 0;
    int  hold_left      = 0;
    int  stall_left     = 0;
    bit  src_idling     = 1'b0;
    bit  sink_idling    = 1'b0;

    function automatic t_op_class decode_class(input logic [7:0] op);
        t_op_class c;
        c = CL_U;
        if (op[1:0] == 2'b01) begin
            case (op[7:5])
                3'd0: c = CL_ORA;
                3'd1: c = CL_AND;
                3'd2: c = CL_EOR;
                3'd3: c = CL_ADD;
                3'd4: c = (op == OP_NOP_IMM) ? CL_NOP : CL_STA;
                3'd5: c = CL_LDA;
                3'd6: c = CL_CMP;
                default: c = CL_SUB;
            endcase
        end else begin
            case (op)
                8'h00: c = CL_BRK;
                8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0: c = CL_BR;
                8'h08, 8'h20, 8'h28, 8'h40, 8'h48, 8'h4C, 8'h60, 8'h68, 8'h6C: c = CL_STK;
                8'h04, 8'h0C, 8'h14, 8'h1C, 8'h34, 8'h3C, 8'h44, 8'h54, 8'h5C, 8'h64,
                8'h74, 8'h7C, 8'h80, 8'hD4, 8'hDC, 8'hF4, 8'hFC, 8'h1A, 8'h3A, 8'h5A,
                8'h7A, 8'h82, 8'hC2, 8'hDA, 8'hE2, 8'hEA, 8'hFA: c = CL_NOP;
                8'h24, 8'h2C: c = CL_BIT;
                8'h84, 8'h8C, 8'h94: c = CL_STY;
                8'h86, 8'h8E, 8'h96: c = CL_STX;
                8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC: c = CL_LDY;
                8'hA2, 8'hA6, 8'hAE, 8'hB6, 8'hBE: c = CL_LDX;
                8'hC0, 8'hC4, 8'hCC: c = CL_CPY;
                8'hE0, 8'hE4, 8'hEC: c = CL_CPX;
                8'h06, 8'h0A, 8'h0E, 8'h16, 8'h1E: c = CL_ASL;
                8'h26, 8'h2A, 8'h2E, 8'h36, 8'h3E: c = CL_ROL;
                8'h46, 8'h4A, 8'h4E, 8'h56, 8'h5E: c = CL_LSR;
                8'h66, 8'h6A, 8'h6E, 8'h76, 8'h7E: c = CL_ROR;
                8'hC6, 8'hCE, 8'hD6, 8'hDE: c = CL_DEC;
                8'hE6, 8'hEE, 8'hF6, 8'hFE: c = CL_INC;
                8'hE8: c = CL_INX;
                8'hC8: c = CL_INY;
                8'hCA: c = CL_DEX;
                8'h88: c = CL_DEY;
                8'hAA: c = CL_TAX;
                8'hA8: c = CL_TAY;
                8'h8A: c = CL_TXA;
                8'h98: c = CL_TYA;
                8'hBA: c = CL_TSX;
                8'h9A: c = CL_TXS;
                8'h18: c = CL_CLC;
                8'h38: c = CL_SEC;
                8'h58: c = CL_CLI;
                8'h78: c = CL_SEI;
                8'hB8: c = CL_CLV;
                8'hD8: c = CL_CLD;
                8'hF8: c = CL_SED;
                8'hEB: c = CL_SUB;
                default: c = CL_U;
            endcase
        end
        return c;
    endfunction

    function automatic logic [7:0] nz_update(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] q;
        q      = p;
        q[P_N] = v[7];
        q[P_Z] = (v == 8'h00);
        return q;
    endfunction

    function automatic logic [7:0] cmp_flags(input logic [7:0] p, input logic [7:0] r,
                                             input logic [7:0] m);
        logic [7:0] q;
        q      = nz_update(p, r - m);
        q[P_C] = (r >= m);
        return q;
    endfunction

    // Executes one instruction on the shadow registers and returns the result it yields.
    function automatic t_out_item execute_instr(input t_in_item it);
        t_out_item   res;
        t_op_class   cls;
        logic [7:0]  a, x, y, s, p, m, v, r, addend;
        logic [8:0]  sum;
        logic [15:0] tgt;
        logic        acc_mode, flag;
        a   = cpu_regs.a;
        x   = cpu_regs.x;
        y   = cpu_regs.y;
        s   = cpu_regs.s;
        p   = cpu_regs.p;
        m   = it.operand;
        cls = decode_class(it.opcode);
        acc_mode = (it.opcode[3:0] == 4'hA);
        v   = acc_mode ? a : m;
        res = '0;
        res.pc_out     = it.next_pc;
        res.cycle_code = CYC_ONE;
        case (cls)
            CL_ORA: begin a = a | m; p = nz_update(p, a); end
            CL_AND: begin a = a & m; p = nz_update(p, a); end
            CL_EOR: begin a = a ^ m; p = nz_update(p, a); end
            CL_ADD, CL_SUB: begin
                addend = (cls == CL_SUB) ? ~m : m;
                sum    = {1'b0, a} + {1'b0, addend} + {8'd0, p[P_C]};
                r      = sum[7:0];
                p[P_V] = (a[7] ^ r[7]) & (addend[7] ^ r[7]);
                p[P_C] = sum[8];
                a      = r;
                p      = nz_update(p, a);
            end
            CL_CMP: p = cmp_flags(p, a, m);
            CL_CPX: p = cmp_flags(p, x, m);
            CL_CPY: p = cmp_flags(p, y, m);
            CL_BIT: begin
                p[P_N] = m[7];
                p[P_V] = m[6];
                p[P_Z] = ((a & m) == 8'h00);
            end
            CL_LDA: begin a = m; p = nz_update(p, m); end
            CL_LDX: begin x = m; p = nz_update(p, m); end
            CL_LDY: begin y = m; p = nz_update(p, m); end
            CL_STA: begin res.mem_write = 1'b1; res.write_data = a; end
            CL_STX: begin res.mem_write = 1'b1; res.write_data = x; end
            CL_STY: begin res.mem_write = 1'b1; res.write_data = y; end
            CL_ASL, CL_ROL, CL_LSR, CL_ROR: begin
                res.cycle_code = CYC_TWO;
                case (cls)
                    CL_ASL:  r = {v[6:0], 1'b0};
                    CL_ROL:  r = {v[6:0], p[P_C]};
                    CL_LSR:  r = {1'b0, v[7:1]};
                    default: r = {p[P_C], v[7:1]};
                endcase
                p[P_C] = (cls == CL_ASL || cls == CL_ROL) ? v[7] : v[0];
                p = nz_update(p, r);
                if (acc_mode) begin
                    a = r;
                end else begin
                    res.mem_write  = 1'b1;
                    res.write_data = r;
                end
            end
            CL_INC, CL_DEC: begin
                res.cycle_code = CYC_TWO;
                r = (cls == CL_INC) ? m + 8'd1 : m - 8'd1;
                p = nz_update(p, r);
                res.mem_write  = 1'b1;
                res.write_data = r;
            end
            CL_INX: begin res.cycle_code = CYC_TWO; x = x + 8'd1; p = nz_update(p, x); end
            CL_INY: begin res.cycle_code = CYC_TWO; y = y + 8'd1; p = nz_update(p, y); end
            CL_DEX: begin res.cycle_code = CYC_TWO; x = x - 8'd1; p = nz_update(p, x); end
            CL_DEY: begin res.cycle_code = CYC_TWO; y = y - 8'd1; p = nz_update(p, y); end
            CL_TAX: begin res.cycle_code = CYC_TWO; x = a; p = nz_update(p, a); end
            CL_TAY: begin res.cycle_code = CYC_TWO; y = a; p = nz_update(p, a); end
            CL_TXA: begin res.cycle_code = CYC_TWO; a = x; p = nz_update(p, a); end
            CL_TYA: begin res.cycle_code = CYC_TWO; a = y; p = nz_update(p, a); end
            CL_TSX: begin res.cycle_code = CYC_TWO; x = s; p = nz_update(p, s); end
            CL_TXS: begin res.cycle_code = CYC_TWO; s = x; end
            CL_CLC: begin res.cycle_code = CYC_TWO; p[P_C] = 1'b0; end
            CL_SEC: begin res.cycle_code = CYC_TWO; p[P_C] = 1'b1; end
            CL_CLI: begin res.cycle_code = CYC_TWO; p[P_I] = 1'b0; end
            CL_SEI: begin res.cycle_code = CYC_TWO; p[P_I] = 1'b1; end
            CL_CLV: begin res.cycle_code = CYC_TWO; p[P_V] = 1'b0; end
            CL_CLD: begin res.cycle_code = CYC_TWO; p[P_D] = 1'b0; end
            CL_SED: begin res.cycle_code = CYC_TWO; p[P_D] = 1'b1; end
            CL_NOP: res.cycle_code = CYC_TWO;
            CL_BRK: begin
                res.cycle_code = CYC_THREE;
                p[P_I]     = 1'b1;
                res.pc_out = BRK_VECTOR;
            end
            CL_BR: begin
                case (it.opcode[7:6])
                    2'd0:    flag = p[P_N];
                    2'd1:    flag = p[P_V];
                    2'd2:    flag = p[P_C];
                    default: flag = p[P_Z];
                endcase
                if (flag == it.opcode[5]) begin
                    tgt = it.next_pc + {{8{m[7]}}, m};
                    res.cycle_code = (tgt[15:8] != it.next_pc[15:8]) ? CYC_TWO : CYC_ONE;
                    res.pc_out     = tgt;
                end
            end
            CL_STK: res.unsupported = 1'b1;
            default: begin
                res.unsupported = 1'b1;
                res.cycle_code  = CYC_NONE;
            end
        endcase
        res.acc_value   = a;
        res.x_value     = x;
        res.y_value     = y;
        res.sp_value    = s;
        res.flags_value = p;
        cpu_regs = '{a: a, x: x, y: y, s: s, p: p};
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] pick_operand();
        logic [7:0] corners[6] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
        if ($urandom_range(0, 9) < 3) return corners[$urandom_range(0, 5)];
        return 8'($urandom_range(0, 255));
    endfunction

    // biased toward page edges so branches cross pages and wrap
    function automatic logic [15:0] pick_pc();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return {8'($urandom_range(0, 255)), 8'($urandom_range(8'hF0, 8'hFF))};
        if (r < 3) return {8'($urandom_range(0, 255)), 8'($urandom_range(0, 8'h0F))};
        if (r < 4) return {($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00,
                           8'($urandom_range(0, 255))};
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic logic [7:0] pick_opcode();
        logic [7:0] op;
        if ($urandom_range(0, 9) < 3) return 8'($urandom_range(0, 255));
        do op = 8'($urandom_range(0, 255)); while (decode_class(op) == CL_U);
        return op;
    endfunction

    task automatic issue_instr(input logic [7:0] op, input logic [7:0] opnd,
                               input logic [15:0] npc);
        t_in_item item;
        int       gap;
        item.opcode  = op;
        item.operand = opnd;
        item.next_pc = npc;
        gap = (src_idling && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= item;
        do @(posedge clk); while (!in_ch.ready);
        expected_results.push_back(execute_instr(item));
        instr_count++;
    endtask

    task automatic input_idle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] got_val);
        if (exp_val !== got_val) begin
            $error("%s: expected %h, got %h", name, exp_val, got_val);
            mismatch_count++;
        end
    endtask

    task automatic test_directed_corners();
        src_idling  = 1'b0;
        sink_idling = 1'b0;
        issue_instr(OP_LDA_IMM, 8'h00, 16'h0000);
        issue_instr(OP_CLC,     8'h00, 16'h0201);
        issue_instr(OP_LDA_IMM, 8'h7F, 16'h0203);
        issue_instr(OP_ADC_IMM, 8'h01, 16'h0205);  // signed overflow into N
        issue_instr(OP_ADC_IMM, 8'h80, 16'h0207);  // carry out, zero, overflow
        issue_instr(OP_SED,     8'h00, 16'h0208);
        issue_instr(OP_SBC_IMM, 8'hFF, 16'h020A);  // binary even with D set
        issue_instr(OP_SBC_ALT, 8'h00, 16'h020C);
        issue_instr(OP_LDA_IMM, 8'hFF, 16'h020E);
        issue_instr(OP_CMP_IMM, 8'hFF, 16'h0210);  // equal: C and Z
        issue_instr(OP_CPX_IMM, 8'h01, 16'h0212);  // less: C clear, N set
        issue_instr(OP_LDA_IMM, 8'h3F, 16'h0214);
        issue_instr(OP_BIT_ZP,  8'hC0, 16'h0216);  // Z from A and M, N V from M
        issue_instr(OP_ASL_A,   8'hFF, 16'h0217);  // acc form, no write
        issue_instr(OP_ROL_A,   8'h00, 16'h0218);
        issue_instr(OP_LSR_ZP,  8'h01, 16'h021A);  // carry from bit 0
        issue_instr(OP_ROR_ZP,  8'h01, 16'h021C);  // carry in at bit 7
        issue_instr(OP_INC_ZP,  8'hFF, 16'h021E);
        issue_instr(OP_DEC_ZP,  8'h00, 16'h0220);
        issue_instr(OP_STA_ZP,  8'h10, 16'h0222);
        issue_instr(OP_TXS,     8'h00, 16'h0223);  // no flag change
        issue_instr(OP_TSX,     8'h00, 16'h0224);
        issue_instr(OP_BRK,     8'h00, 16'hFFFF);
        issue_instr(OP_SEC,     8'h00, 16'h10EF);
        issue_instr(OP_BCS,     8'h7F, 16'h10F0);  // taken across a page
        issue_instr(OP_BEQ,     8'h80, 16'h0005);  // backward, wraps below zero
        issue_instr(OP_BNE,     8'h80, 16'h0007);  // not taken
        issue_instr(OP_PHA,     8'h00, 16'h0300);
        issue_instr(OP_JAM,     8'hFF, 16'h0301);
        issue_instr(OP_NOP_IMM, 8'h55, 16'h0303);
    endtask

    task automatic test_opcode_sweep();
        src_idling  = 1'b1;
        sink_idling = 1'b1;
        for (int i = 0; i < 256; i++) begin
            issue_instr(8'(i), pick_operand(), pick_pc());
        end
    endtask

    task automatic test_branch_pages();
        logic [7:0] setters[7] = '{OP_CLC, OP_SEC, OP_CLV, OP_LDA_IMM, OP_ADC_IMM,
                                   OP_CMP_IMM, OP_BIT_ZP};
        src_idling  = 1'b1;
        sink_idling = 1'b0;
        for (int i = 0; i < 60; i++) begin
            issue_instr(setters[$urandom_range(0, 6)], pick_operand(), pick_pc());
            issue_instr({3'($urandom_range(0, 7)), BRANCH_LOW}, pick_operand(), pick_pc());
        end
    endtask

    // receiver stalls for a long stretch while the sender keeps pushing
    task automatic test_back_pressure();
        src_idling   = 1'b0;
        sink_idling  = 1'b0;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 24; i++) begin
            issue_instr(pick_opcode(), pick_operand(), pick_pc());
        end
    endtask

    task automatic test_random_mix();
        for (int chunk = 0; chunk < 11; chunk++) begin
            src_idling  = ($urandom_range(0, 2) != 0);
            sink_idling = ($urandom_range(0, 2) != 0);
            for (int i = 0; i < 100; i++) begin
                issue_instr(pick_opcode(), pick_operand(), pick_pc());
            end
        end
    endtask

    // result sink
    initial begin
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_left == 0 && hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (sink_idling && $urandom_range(0, 2) == 0) stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            result_count++;
            if (out_ch.data.mem_write === 1'b1) write_count++;
            if (out_ch.data.unsupported === 1'b1) unsup_count++;
            if (expected_results.size() == 0) begin
                $error("result transfer with no instruction outstanding");
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("pc_out",      want.pc_out,      out_ch.data.pc_out);
                check_field("mem_write",   want.mem_write,   out_ch.data.mem_write);
                check_field("write_data",  want.write_data,  out_ch.data.write_data);
                check_field("acc_value",   want.acc_value,   out_ch.data.acc_value);
                check_field("x_value",     want.x_value,     out_ch.data.x_value);
                check_field("y_value",     want.y_value,     out_ch.data.y_value);
                check_field("sp_value",    want.sp_value,    out_ch.data.sp_value);
                check_field("flags_value", want.flags_value, out_ch.data.flags_value);
                check_field("cycle_code",  want.cycle_code,  out_ch.data.cycle_code);
                check_field("unsupported", want.unsupported, out_ch.data.unsupported);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        rst_n       = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        cpu_regs    = '{a: RST_A, x: RST_X, y: RST_Y, s: RST_S, p: RST_P};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_corners();
        test_opcode_sweep();
        test_branch_pages();
        test_back_pressure();
        test_random_mix();

        input_idle();
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d instructions over all opcodes, %0d results checked", instr_count,
                 result_count);
        $display("%0d memory writes, %0d unsupported, %0d mismatches", write_count,
                 unsup_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
